>>> rtl/bsrs_pkg.sv
// bsrs_pkg: shared types, sizes and operation codes of the bounded set unit
// no dependencies; imported by every module of the block
`default_nettype none

package bsrs_pkg;

   localparam int DEPTH            = 16;
   localparam int ITEM_WIDTH       = 32;
   localparam int DEFAULT_CAPACITY = 16;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CAP_W  = 5;
   localparam int KIND_W = 2;
   localparam int RANK_W = 8;
   localparam int OUT_W  = 32;
   localparam int OCC_W  = 5;

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   localparam logic [ADDR_W-1:0] REG_CAPACITY = ADDR_W'(0);

   localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERASE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_GET      = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [31:0]       item_value;
      logic [RANK_W-1:0] rank_index;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [OUT_W-1:0] item_out;
      logic [OCC_W-1:0] occupancy;
      logic             is_empty;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

   // capacity beyond the array depth acts as the depth
   function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] res;
      if (32'(cap) > DEPTH) begin
         res = CNT_W'(DEPTH);
      end else begin
         res = CNT_W'(cap);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bsrs_cmp.sv
// bsrs_cmp: shared magnitude / equality comparator for stored words
// depends on bsrs_pkg
`default_nettype none

module bsrs_cmp (
   input  wire logic [bsrs_pkg::ITEM_WIDTH-1:0] a,
   input  wire logic [bsrs_pkg::ITEM_WIDTH-1:0] b,
   output logic                                 a_eq_b,
   output logic                                 a_gt_b
);
   import bsrs_pkg::*;

   assign a_eq_b = (a == b);
   assign a_gt_b = (a > b);

endmodule

`default_nettype wire

>>> rtl/bsrs_engine.sv
// bsrs_engine: entry memory and the sequencer that drives the shared comparator
// depends on bsrs_pkg and bsrs_cmp
`default_nettype none

module bsrs_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire bsrs_pkg::req_type            req,
   input  wire logic [bsrs_pkg::CAP_W-1:0]   capacity,
   input  wire logic                         out_free,
   output bsrs_pkg::eng_stat_type            stat,
   output bsrs_pkg::rsp_type                 result
);
   import bsrs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOC_RD,
      ST_LOC_CMP,
      ST_LOC_DONE,
      ST_ER_RD,
      ST_ER_WR,
      ST_SEL_RDJ,
      ST_SEL_LDJ,
      ST_SEL_RDK,
      ST_SEL_CMP,
      ST_SEL_CHK,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [ITEM_WIDTH-1:0]   value_ff, value_in;
   logic [RANK_W-1:0]       rank_ff, rank_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic                    found_ff, found_in;
   logic [ITEM_WIDTH-1:0]   vj_ff, vj_in;
   logic [CNT_W-1:0]        below_ff, below_in;
   logic                    ok_ff, ok_in;
   logic [ITEM_WIDTH-1:0]   item_ff, item_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;

   logic [ITEM_WIDTH-1:0]   mem [DEPTH];
   logic [ITEM_WIDTH-1:0]   rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   logic [ITEM_WIDTH-1:0]   mem_wdata;

   logic [ITEM_WIDTH-1:0]   cmp_a;
   logic                    cmp_eq;
   logic                    cmp_gt;
   logic [CNT_W-1:0]        last_pos;
   logic                    idx_last;
   logic                    j_last;
   logic [CNT_W-1:0]        cap_eff;
   logic                    in_select;

   assign cap_eff   = eff_capacity(capacity);
   assign last_pos  = fill_ff - CNT_W'(1);
   assign idx_last  = (CNT_W'(idx_ff) == last_pos);
   assign j_last    = (CNT_W'(j_ff) == last_pos);
   assign in_select = (state_ff == ST_SEL_CMP);

   // one comparator: stored word against the key, or against the pivot in select
   assign cmp_a = in_select ? vj_ff : value_ff;

   bsrs_cmp u_cmp (
      .a      (cmp_a),
      .b      (rd_data_ff),
      .a_eq_b (cmp_eq),
      .a_gt_b (cmp_gt)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      rank_in   = rank_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      slot_in   = slot_ff;
      found_in  = found_ff;
      vj_in     = vj_ff;
      below_in  = below_ff;
      ok_in     = ok_ff;
      item_in   = item_ff;
      fill_in   = fill_ff;
      rd_addr   = idx_ff;
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req.kind;
               value_in = ITEM_WIDTH'(req.item_value);
               rank_in  = req.rank_index;
               ok_in    = 1'b0;
               item_in  = '0;
               found_in = 1'b0;
               idx_in   = '0;
               j_in     = '0;
               if (req.kind == KIND_GET) begin
                  if (RANK_W'(fill_ff) <= req.rank_index) begin
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_SEL_RDJ;
                  end
               end else if (req.kind == KIND_INSERT && fill_ff >= cap_eff) begin
                  state_in = ST_FINISH;
               end else if (fill_ff == '0) begin
                  state_in = ST_LOC_DONE;
               end else begin
                  state_in = ST_LOC_RD;
               end
            end
         end
         ST_LOC_RD: begin
            state_in = ST_LOC_CMP;
         end
         ST_LOC_CMP: begin
            if (cmp_eq) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               state_in = ST_LOC_DONE;
            end else if (idx_last) begin
               state_in = ST_LOC_DONE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_LOC_RD;
            end
         end
         ST_LOC_DONE: begin
            state_in = ST_FINISH;
            case (kind_ff)
               KIND_INSERT: begin
                  if (!found_ff) begin
                     mem_we    = 1'b1;
                     mem_waddr = fill_ff[IDX_W-1:0];
                     mem_wdata = value_ff;
                     fill_in   = fill_ff + CNT_W'(1);
                     ok_in     = 1'b1;
                  end
               end
               KIND_ERASE: begin
                  if (found_ff) begin
                     state_in = ST_ER_RD;
                  end
               end
               KIND_CONTAINS: begin
                  ok_in = found_ff;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         ST_ER_RD: begin
            // fetch the last entry to fill the hole
            rd_addr  = last_pos[IDX_W-1:0];
            state_in = ST_ER_WR;
         end
         ST_ER_WR: begin
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = rd_data_ff;
            fill_in   = last_pos;
            ok_in     = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_SEL_RDJ: begin
            rd_addr  = j_ff;
            state_in = ST_SEL_LDJ;
         end
         ST_SEL_LDJ: begin
            vj_in    = rd_data_ff;
            idx_in   = '0;
            below_in = '0;
            state_in = ST_SEL_RDK;
         end
         ST_SEL_RDK: begin
            state_in = ST_SEL_CMP;
         end
         ST_SEL_CMP: begin
            if (idx_ff != j_ff && cmp_gt) begin
               below_in = below_ff + CNT_W'(1);
            end
            if (idx_last) begin
               state_in = ST_SEL_CHK;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SEL_RDK;
            end
         end
         ST_SEL_CHK: begin
            if (RANK_W'(below_ff) == rank_ff) begin
               ok_in    = 1'b1;
               item_in  = vj_ff;
               state_in = ST_FINISH;
            end else if (j_last) begin
               state_in = ST_FINISH;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_SEL_RDJ;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      kind_ff  <= kind_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
      idx_ff   <= idx_in;
      j_ff     <= j_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
      vj_ff    <= vj_in;
      below_ff <= below_in;
      ok_ff    <= ok_in;
      item_ff  <= item_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_FINISH);

   assign result.ok        = ok_ff;
   assign result.item_out  = OUT_W'(item_ff);
   assign result.occupancy = OCC_W'(fill_ff);
   assign result.is_empty  = (fill_ff == '0);

endmodule

`default_nettype wire

>>> rtl/bounded_set_with_rank_select_unit.sv
// bounded_set_with_rank_select_unit: top level with request/response words and csr port
// depends on bsrs_pkg, bsrs_engine (which holds bsrs_cmp)
// insert/erase/contains scan the entries up to a match, and a hitting erase then moves the last
//   entry into the hole; get scans all entries per candidate entry; early refusals skip the scan
// throughput: one word at a time; the sequencer and its single comparator set the rate
// reset: synchronous active high, set empties, capacity returns to 16, response invalid
`default_nettype none

module bounded_set_with_rank_select_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire bsrs_pkg::req_type             req_word,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output bsrs_pkg::rsp_type                  rsp_word,
   // csr port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bsrs_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [bsrs_pkg::DATA_W-1:0]   pwdata,
   output logic [bsrs_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import bsrs_pkg::*;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_word_ff, rsp_word_in;

   eng_stat_type     eng_stat;
   rsp_type          eng_result;
   logic             start;
   logic             out_free;
   logic             csr_write;
   logic             csr_hit;

   // register index is the word address; only the capacity register exists
   assign csr_hit   = (paddr[ADDR_W-1:2] == REG_CAPACITY[ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? DATA_W'(capacity_ff) : '0;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write && csr_hit) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   // request is taken only when the sequencer is idle
   assign req_ready = eng_stat.idle;
   assign start     = req_valid && req_ready;

   // output register frees the sequencer once a result is parked
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (eng_stat.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = eng_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_W'(DEFAULT_CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   bsrs_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_word),
      .capacity (capacity_ff),
      .out_free (out_free),
      .stat     (eng_stat),
      .result   (eng_result)
   );

endmodule

`default_nettype wire

>>> verif/bounded_set_with_rank_select_unit_tb.sv
// testbench for bounded_set_with_rank_select_unit: insert/erase/contains/get words
// checked against an in-bench set predictor; depends on bsrs_pkg and the rtl top only
module bounded_set_with_rank_select_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsrs_pkg::*;

   localparam int unsigned STALL_LIMIT  = 4000; // above the longest get at full occupancy
   localparam int unsigned DRAIN_CYCLES = 600;
   localparam int unsigned POOL_SIZE    = 24;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_WORDS  = 116;

   // set predictor plus the queue of responses it has promised
   class set_scoreboard;
      logic [ITEM_WIDTH-1:0] members[DEPTH];
      int unsigned           member_count;
      int unsigned           peak_count;
      logic [CAP_W-1:0]      capacity;
      rsp_type               expected_q[$];
      int unsigned           error_count;
      int unsigned           checked_count;
      int unsigned           kind_count[4];

      function new();
         member_count  = 0;
         peak_count    = 0;
         capacity      = CAP_W'(DEFAULT_CAPACITY);
         error_count   = 0;
         checked_count = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // a capacity past the array depth is clipped to the depth
      function int unsigned room();
         return (capacity > DEPTH) ? DEPTH : capacity;
      endfunction

      function int find_slot(logic [ITEM_WIDTH-1:0] v);
         int s;
         for (s = 0; s < member_count; s++)
            if (members[s] == v) return s;
         return -1;
      endfunction

      // rank of an entry is the number of entries smaller than it
      function bit select_by_rank(int unsigned rank, output logic [ITEM_WIDTH-1:0] found);
         int unsigned j, k, below;
         found = '0;
         if (rank >= member_count) return 1'b0;
         for (j = 0; j < member_count; j++) begin
            below = 0;
            for (k = 0; k < member_count; k++)
               if (k != j && members[j] > members[k]) below++;
            if (below == rank) begin
               found = members[j];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(req_type w);
         rsp_type               e;
         int                    slot;
         logic [ITEM_WIDTH-1:0] v;
         logic [ITEM_WIDTH-1:0] found;
         e = '0;
         v = w.item_value[ITEM_WIDTH-1:0];
         kind_count[w.kind]++;
         case (w.kind)
            KIND_INSERT: begin
               if (member_count < room() && find_slot(v) < 0) begin
                  members[member_count] = v;
                  member_count++;
                  e.ok = 1'b1;
               end
            end
            KIND_ERASE: begin
               slot = find_slot(v);
               if (slot >= 0) begin
                  // last entry fills the hole
                  members[slot] = members[member_count - 1];
                  member_count--;
                  e.ok = 1'b1;
               end
            end
            KIND_CONTAINS: begin
               e.ok = (find_slot(v) >= 0);
            end
            default: begin
               e.ok = select_by_rank(w.rank_index, found);
               e.item_out = e.ok ? OUT_W'(found) : '0;
            end
         endcase
         if (member_count > peak_count) peak_count = member_count;
         e.occupancy = OCC_W'(member_count);
         e.is_empty  = (member_count == 0);
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response word with nothing outstanding: %p", got);
            error_count++;
            return;
         end
         e = expected_q.pop_front();
         checked_count++;
         if (got.ok !== e.ok) begin
            $error("ok mismatch: expected %0h, actual %0h", e.ok, got.ok);
            error_count++;
         end
         if (got.item_out !== e.item_out) begin
            $error("item_out mismatch: expected %0h, actual %0h", e.item_out, got.item_out);
            error_count++;
         end
         if (got.occupancy !== e.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", e.occupancy, got.occupancy);
            error_count++;
         end
         if (got.is_empty !== e.is_empty) begin
            $error("is_empty mismatch: expected %0h, actual %0h", e.is_empty, got.is_empty);
            error_count++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_word;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_word;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   set_scoreboard sb = new();
   bit            no_idle = 1'b0;   // set for the stretch with back-to-back traffic
   int unsigned   csr_writes = 0;

   bounded_set_with_rank_select_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random back-pressure, check every accepted word
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_word);
         @(negedge clock);
         rsp_ready <= no_idle || ($urandom_range(99) >= 34);
      end
   end

   // watchdog: too many cycles in a row with no word moving on either channel
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // entered and left at a falling edge; valid stays up after the accept
   // so the caller either sends again or drops it at this edge
   task automatic send_request(input req_type w);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [31:0] value,
                          input logic [RANK_W-1:0] rank);
      req_type w;
      w.kind       = kind;
      w.item_value = value;
      w.rank_index = rank;
      send_request(w);
   endtask

   // one apb transfer: setup then access, ends at a falling edge with psel low
   task automatic csr_cycle(input bit is_write, input logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] read_data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= REG_CAPACITY;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      read_data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // only called with the block idle: request valid low, nothing outstanding
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] seen;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
      data            = $urandom;   // upper bits are don't-care
      data[CAP_W-1:0] = cap;
      csr_cycle(1'b1, data, seen);
      sb.set_capacity(cap);
      csr_writes++;
      @(negedge clock);
      csr_cycle(1'b0, '0, seen);
      if (seen[CAP_W-1:0] !== cap) begin
         $error("capacity readback mismatch: expected %0d, actual %0d", cap, seen[CAP_W-1:0]);
         sb.error_count++;
      end
   endtask

   initial begin
      req_type               w;
      logic [31:0]           pool[POOL_SIZE];
      logic [CAP_W-1:0]      caps[PHASES];
      int unsigned           ins_weight[PHASES];
      int unsigned           phase, n, roll;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, capacity at its reset value of 16 ----
      send_op(KIND_GET,      32'h0,          8'd0);    // get on an empty set
      send_op(KIND_ERASE,    32'h5,          8'd0);    // erase of an absent value
      send_op(KIND_CONTAINS, 32'h0,          8'd0);
      send_op(KIND_INSERT,   32'h0,          8'd0);    // smallest value
      send_op(KIND_INSERT,   32'hFFFF_FFFF,  8'd0);    // largest value
      send_op(KIND_INSERT,   32'h0,          8'd0);    // duplicate insert fails
      send_op(KIND_INSERT,   32'h1234_5678,  8'hFF);
      send_op(KIND_CONTAINS, 32'hFFFF_FFFF,  8'd0);
      send_op(KIND_GET,      32'hFFFF_FFFF,  8'd0);
      send_op(KIND_GET,      32'h0,          8'd1);
      send_op(KIND_GET,      32'h0,          8'd2);
      send_op(KIND_GET,      32'h0,          8'd3);    // rank equal to occupancy
      send_op(KIND_GET,      32'h0,          8'hFF);   // rank far past occupancy
      send_op(KIND_ERASE,    32'h0,          8'd0);    // last entry moves into slot 0
      send_op(KIND_ERASE,    32'h0,          8'd0);
      send_op(KIND_GET,      32'h0,          8'd0);
      send_op(KIND_INSERT,   32'h8000_0000,  8'd0);
      req_valid <= 1'b0;

      // capacity dropped below occupancy: inserts refused, contents kept
      set_capacity(CAP_W'(1));
      send_op(KIND_INSERT,   32'h7,          8'd0);
      send_op(KIND_CONTAINS, 32'h8000_0000,  8'd0);
      req_valid <= 1'b0;
      set_capacity(CAP_W'(0));
      send_op(KIND_ERASE,    32'hFFFF_FFFF,  8'd0);
      send_op(KIND_INSERT,   32'hFFFF_FFFF,  8'd0);
      send_op(KIND_GET,      32'h0,          8'd1);
      req_valid <= 1'b0;

      // ---- random phases, each with its own capacity and op mix ----
      // 31 is past the depth, then a small cap against a full set, then zero
      caps       = '{5'd31, 5'd3, 5'd0, 5'd16, 5'd8, 5'd20, 5'd1, 5'd16};
      caps[4]    = CAP_W'($urandom_range(1, 15));
      ins_weight = '{55, 15, 20, 40, 35, 50, 25, 40};

      for (phase = 0; phase < PHASES; phase++) begin
         set_capacity(caps[phase]);
         no_idle = (phase == 3);
         // values likely to collide, with both ends of the range always present
         pool[0] = 32'h0;
         pool[1] = 32'hFFFF_FFFF;
         for (n = 2; n < POOL_SIZE; n++) pool[n] = $urandom;

         for (n = 0; n < PHASE_WORDS; n++) begin
            roll         = $urandom_range(99);
            w.item_value = $urandom;
            w.rank_index = RANK_W'($urandom);
            if (roll < ins_weight[phase])            w.kind = KIND_INSERT;
            else if (roll < ins_weight[phase] + 20)  w.kind = KIND_ERASE;
            else if (roll < ins_weight[phase] + 35)  w.kind = KIND_CONTAINS;
            else                                     w.kind = KIND_GET;

            if (w.kind == KIND_GET) begin
               // mostly valid ranks plus the one just past the end
               if ($urandom_range(4) != 0)
                  w.rank_index = RANK_W'($urandom_range(0, sb.member_count));
            end else if ($urandom_range(99) < 85) begin
               if (w.kind != KIND_INSERT && sb.member_count > 0 && $urandom_range(1) == 1)
                  w.item_value = sb.members[$urandom_range(0, sb.member_count - 1)];
               else
                  w.item_value = pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_request(w);
         end
         req_valid <= 1'b0;
      end
      no_idle = 1'b0;

      // drain: everything back, then a quiet window for stray words
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d inserts, %0d erases, %0d contains, %0d gets; %0d words checked",
               sb.kind_count[KIND_INSERT], sb.kind_count[KIND_ERASE],
               sb.kind_count[KIND_CONTAINS], sb.kind_count[KIND_GET], sb.checked_count);
      $display("capacity written %0d times (0 through 31), occupancy peaked at %0d",
               csr_writes, sb.peak_count);
      if (sb.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
